/* rtl/core/m3i_pkg.sv */
// shared types, widths and the output saturation helper for the 3x3 matrix inverse
// no dependencies; the front, back and top files of the block refer to it by scoped names
package m3i_pkg;

    localparam int DW   = 32;
    localparam int CW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 1;

    localparam logic [DETW-1:0] HALF_MAG = {{(DETW-1){1'b0}}, 1'b1} << (DW - 1);

    typedef struct packed {
        logic signed [DW-1:0] a00;
        logic signed [DW-1:0] a01;
        logic signed [DW-1:0] a02;
        logic signed [DW-1:0] a10;
        logic signed [DW-1:0] a11;
        logic signed [DW-1:0] a12;
        logic signed [DW-1:0] a20;
        logic signed [DW-1:0] a21;
        logic signed [DW-1:0] a22;
    } matrix_t;

    typedef struct packed {
        logic signed [DW-1:0] inv00;
        logic signed [DW-1:0] inv01;
        logic signed [DW-1:0] inv02;
        logic signed [DW-1:0] inv10;
        logic signed [DW-1:0] inv11;
        logic signed [DW-1:0] inv12;
        logic signed [DW-1:0] inv20;
        logic signed [DW-1:0] inv21;
        logic signed [DW-1:0] inv22;
        logic signed [DW-1:0] determinant;
        logic                 singular;
    } result_t;

    // exact cofactors and determinant handed from front to back
    typedef struct packed {
        logic [8:0][CW-1:0] cof;
        logic [DETW-1:0]    det;
        logic [DW-1:0]      det_field;
        logic               singular;
    } cof_item_t;

    // sign and magnitude to a saturated two's complement field
    function automatic logic [DW-1:0] sat_field(input logic neg, input logic [DETW-1:0] mag);
        logic [DW-1:0] low;
        low = mag[DW-1:0];
        if (neg)
        begin
            if (mag > HALF_MAG)
            begin
                return HALF_MAG[DW-1:0];
            end
            return -low;
        end
        if (mag >= HALF_MAG)
        begin
            return ~HALF_MAG[DW-1:0];
        end
        return low;
    endfunction

endpackage

/* rtl/core/m3i_fifo.sv */
// small register queue used between the pipeline parts and at the result side
// depends on nothing but its parameters
module m3i_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             push_ok, pop_ok;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/core/m3i_front.sv */
// front part: takes matrices, forms the nine cofactors, the exact determinant,
// the rounded determinant field and the singular flag; uses m3i_pkg
module m3i_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  m3i_pkg::matrix_t    matrix,
    output logic                q_push,
    output m3i_pkg::cof_item_t  q_item,
    input  logic                q_full
);

    localparam int DW   = m3i_pkg::DW;
    localparam int CW   = m3i_pkg::CW;
    localparam int DETW = m3i_pkg::DETW;

    // minor rows and columns for each cofactor, row-major
    localparam int R0 [9]  = '{1, 1, 1, 0, 0, 0, 0, 0, 0};
    localparam int R1 [9]  = '{2, 2, 2, 2, 2, 2, 1, 1, 1};
    localparam int C0 [9]  = '{1, 0, 0, 1, 0, 0, 1, 0, 0};
    localparam int C1 [9]  = '{2, 2, 1, 2, 2, 1, 2, 2, 1};
    localparam bit ODD [9] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    logic signed [DW-1:0] a [3][3];

    logic [5:0] v_reg, v_next;
    logic       en;

    logic signed [2*DW-1:0] p_reg [9], p_next [9];
    logic signed [2*DW-1:0] q_reg [9], q_next [9];
    logic signed [DW-1:0]   row0_s0_reg [3];
    logic signed [DW-1:0]   row0_s1_reg [3];
    logic signed [CW-1:0]   cof1_reg [9], cof1_next [9];
    logic signed [CW-1:0]   cof2_reg [9];
    logic signed [CW-1:0]   cof3_reg [9];
    logic signed [CW-1:0]   cof4_reg [9];
    logic signed [CW-1:0]   lo_reg [3], lo_next [3];
    logic signed [CW-1:0]   hi_reg [3], hi_next [3];
    logic signed [DETW-1:0] prod_reg [3], prod_next [3];
    logic signed [DETW-1:0] det4_reg, det4_next;
    logic [DETW-1:0]        mag;
    logic [DETW-1:0]        rnd;
    m3i_pkg::cof_item_t     item5_reg, item5_next;

    assign a[0][0] = matrix.a00;
    assign a[0][1] = matrix.a01;
    assign a[0][2] = matrix.a02;
    assign a[1][0] = matrix.a10;
    assign a[1][1] = matrix.a11;
    assign a[1][2] = matrix.a12;
    assign a[2][0] = matrix.a20;
    assign a[2][1] = matrix.a21;
    assign a[2][2] = matrix.a22;

    // the whole front holds while a finished item cannot enter the queue
    assign en     = !(v_reg[5] && q_full);
    assign full   = !en;
    assign q_push = v_reg[5] && !q_full;
    assign q_item = item5_reg;

    assign v_next = {v_reg[4:0], push};

    always_comb
    begin
        logic signed [CW-1:0] diff;
        diff = '0;
        for (int k = 0; k < 9; k++)
        begin
            p_next[k] = a[R0[k]][C0[k]] * a[R1[k]][C1[k]];
            q_next[k] = a[R0[k]][C1[k]] * a[R1[k]][C0[k]];
            diff = CW'(p_reg[k]) - CW'(q_reg[k]);
            cof1_next[k] = ODD[k] ? -diff : diff;
        end
        // row 0 times cofactor, split so no multiplier exceeds one word by one word plus one bit
        for (int j = 0; j < 3; j++)
        begin
            lo_next[j]   = row0_s1_reg[j] * $signed({1'b0, cof1_reg[j][DW-1:0]});
            hi_next[j]   = row0_s1_reg[j] * $signed(cof1_reg[j][CW-1:DW]);
            prod_next[j] = (DETW'(hi_reg[j]) <<< DW) + DETW'(lo_reg[j]);
        end
        det4_next = prod_reg[0] + prod_reg[1] + prod_reg[2];
    end

    assign mag = det4_reg[DETW-1] ? DETW'(-det4_reg) : DETW'(det4_reg);

    generate
        if (FRAC_BITS == 0)
        begin : g_no_round
            assign rnd = mag;
        end
        else
        begin : g_round
            assign rnd = (mag + (DETW'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
        end
    endgenerate

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            item5_next.cof[k] = cof4_reg[k];
        end
        item5_next.det       = det4_reg;
        item5_next.det_field = m3i_pkg::sat_field(det4_reg[DETW-1], rnd);
        item5_next.singular  = (det4_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg       <= p_next;
            q_reg       <= q_next;
            row0_s0_reg <= '{a[0][0], a[0][1], a[0][2]};
            row0_s1_reg <= row0_s0_reg;
            cof1_reg    <= cof1_next;
            cof2_reg    <= cof1_reg;
            cof3_reg    <= cof2_reg;
            cof4_reg    <= cof3_reg;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            prod_reg    <= prod_next;
            det4_reg    <= det4_next;
            item5_reg   <= item5_next;
        end
    end

endmodule

/* rtl/core/m3i_back.sv */
// back part: nine pipelined restoring dividers, one quotient bit per stage,
// then rounding and saturation of the inverse; uses m3i_pkg
module m3i_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    output logic               q_pop,
    input  m3i_pkg::cof_item_t q_item,
    input  logic               o_full,
    output logic               o_push,
    output m3i_pkg::result_t   o_item
);

    localparam int DW   = m3i_pkg::DW;
    localparam int CW   = m3i_pkg::CW;
    localparam int DETW = m3i_pkg::DETW;
    localparam int QB   = DW + 1;
    localparam int NMW  = 2 * DW + 2 * FRAC_BITS;
    localparam int DMW  = 3 * DW;
    localparam int RW   = DMW + 1;

    // inverse entry (i, j) divides cofactor (j, i)
    localparam int SRC [9] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

    logic [QB:0]     v_reg, v_next;
    logic            vf_reg;
    logic            en;

    logic [RW-1:0]   rem_reg  [QB+1][9], rem_next  [QB+1][9];
    logic [QB-1:0]   quo_reg  [QB+1][9], quo_next  [QB+1][9];
    logic [QB-1:0]   nlo_reg  [QB+1][9], nlo_next  [QB+1][9];
    logic            sign_reg [QB+1][9], sign_next [QB+1][9];
    logic            ov_reg   [QB+1][9], ov_next   [QB+1][9];
    logic [DMW-1:0]  dm_reg   [QB+1],    dm_next   [QB+1];
    logic            sing_reg [QB+1],    sing_next [QB+1];
    logic [DW-1:0]   detf_reg [QB+1],    detf_next [QB+1];

    logic [DW-1:0]    inv [9];
    m3i_pkg::result_t res_reg, res_next;

    assign en     = !(vf_reg && o_full);
    assign q_pop  = en && !q_empty;
    assign o_push = vf_reg && !o_full;
    assign o_item = res_reg;
    assign v_next = {v_reg[QB-1:0], !q_empty};

    always_comb
    begin
        logic signed [DETW-1:0] det;
        logic [DETW-1:0]        det_abs;
        logic signed [CW-1:0]   c;
        logic [CW-1:0]          c_abs;
        logic [NMW-1:0]         nm;
        logic [RW:0]            r2;
        logic                   ge;

        // operand preparation
        det     = $signed(q_item.det);
        det_abs = det[DETW-1] ? DETW'(-det) : DETW'(det);
        dm_next[0]   = det_abs[DMW-1:0];
        sing_next[0] = q_item.singular;
        detf_next[0] = q_item.det_field;
        for (int k = 0; k < 9; k++)
        begin
            c     = $signed(q_item.cof[SRC[k]]);
            c_abs = c[CW-1] ? CW'(-c) : CW'(c);
            nm    = NMW'(c_abs[2*DW-1:0]) << (2 * FRAC_BITS);
            sign_next[0][k] = c[CW-1] ^ det[DETW-1];
            // quotient at or above two to the QB saturates anyway
            ov_next[0][k]   = (nm >> QB) >= det_abs[DMW-1:0];
            rem_next[0][k]  = RW'(nm >> QB);
            nlo_next[0][k]  = nm[QB-1:0];
            quo_next[0][k]  = '0;
        end

        // one quotient bit per stage
        for (int s = 0; s < QB; s++)
        begin
            dm_next[s+1]   = dm_reg[s];
            sing_next[s+1] = sing_reg[s];
            detf_next[s+1] = detf_reg[s];
            for (int k = 0; k < 9; k++)
            begin
                r2 = {rem_reg[s][k], nlo_reg[s][k][QB-1-s]};
                ge = r2 >= (RW+1)'(dm_reg[s]);
                rem_next[s+1][k]  = ge ? RW'(r2 - (RW+1)'(dm_reg[s])) : RW'(r2);
                quo_next[s+1][k]  = {quo_reg[s][k][QB-2:0], ge};
                nlo_next[s+1][k]  = nlo_reg[s][k];
                sign_next[s+1][k] = sign_reg[s][k];
                ov_next[s+1][k]   = ov_reg[s][k];
            end
        end
    end

    // round half away from zero, then saturate
    always_comb
    begin
        logic           up;
        logic [QB:0]    qr;
        logic [DETW-1:0] qmag;
        for (int k = 0; k < 9; k++)
        begin
            up   = {rem_reg[QB][k], 1'b0} >= (RW+1)'(dm_reg[QB]);
            qr   = (QB+1)'(quo_reg[QB][k]) + (QB+1)'(up);
            qmag = ov_reg[QB][k] ? '1 : DETW'(qr);
            inv[k] = sing_reg[QB] ? '0 : m3i_pkg::sat_field(sign_reg[QB][k], qmag);
        end
        res_next.inv00       = inv[0];
        res_next.inv01       = inv[1];
        res_next.inv02       = inv[2];
        res_next.inv10       = inv[3];
        res_next.inv11       = inv[4];
        res_next.inv12       = inv[5];
        res_next.inv20       = inv[6];
        res_next.inv21       = inv[7];
        res_next.inv22       = inv[8];
        res_next.determinant = detf_reg[QB];
        res_next.singular    = sing_reg[QB];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= v_next;
            vf_reg <= v_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            nlo_reg  <= nlo_next;
            sign_reg <= sign_next;
            ov_reg   <= ov_next;
            dm_reg   <= dm_next;
            sing_reg <= sing_next;
            detf_reg <= detf_next;
            res_reg  <= res_next;
        end
    end

endmodule

/* rtl/core/matrix3_inverse.sv */
// top level of the 3x3 matrix inverse: front, cofactor queue, divider back end,
// result queue; uses m3i_pkg, m3i_fifo, m3i_front and m3i_back
//
// One 3x3 matrix of signed fixed-point entries is taken per cycle while full is
// low, and one result (the nine entries of the inverse, the determinant and a
// singular flag) leaves per cycle as long as results are popped. An item passes
// through the front (products, cofactors, determinant, rounding), the two-entry
// cofactor queue, the back (one preparation stage, 33 divider stages each
// producing one quotient bit, one rounding stage) and the two-entry result queue.
// Most of the pipeline lies in the nine pipelined restoring dividers in the back.
// A zero determinant yields singular high with all other fields zero;
// out-of-range results saturate.
module matrix3_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  m3i_pkg::matrix_t  matrix,
    output logic              empty,
    input  logic              pop,
    output m3i_pkg::result_t  result
);

    m3i_pkg::cof_item_t f_item, b_item;
    m3i_pkg::result_t   o_item;
    logic               f_push, mid_full, mid_empty, b_pop;
    logic               o_push, o_full;

    m3i_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .matrix (matrix),
        .q_push (f_push),
        .q_item (f_item),
        .q_full (mid_full)
    );

    m3i_fifo #(.WIDTH($bits(m3i_pkg::cof_item_t)), .DEPTH(2)) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata (f_item),
        .full  (mid_full),
        .pop   (b_pop),
        .rdata (b_item),
        .empty (mid_empty)
    );

    m3i_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (mid_empty),
        .q_pop   (b_pop),
        .q_item  (b_item),
        .o_full  (o_full),
        .o_push  (o_push),
        .o_item  (o_item)
    );

    m3i_fifo #(.WIDTH($bits(m3i_pkg::result_t)), .DEPTH(2)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (o_push),
        .wdata (o_item),
        .full  (o_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.singular) |->
            (result.determinant == '0 && result.inv00 == '0 && result.inv01 == '0 &&
             result.inv02 == '0 && result.inv10 == '0 && result.inv11 == '0 &&
             result.inv12 == '0 && result.inv20 == '0 && result.inv21 == '0 &&
             result.inv22 == '0))
        else $error("singular result carries nonzero fields");

    a_back_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        o_push |=> !empty)
        else $error("item from back end did not reach the result queue");

    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_full && !b_pop && f_push) |-> 1'b0)
        else $error("front pushed into a full cofactor queue");

endmodule
